@@ rtl/core/gsi_pkg.sv @@
// Shared constants, types and command/status bundles of the grid spatial index.
`default_nettype none
package gsi_pkg;
    localparam int SECTOR_SHIFT      = 3;
    localparam int SECTOR_TILES      = 1 << SECTOR_SHIFT;
    localparam int GRID_COLUMNS      = 64;
    localparam int GRID_ROWS         = 64;
    localparam int SECTOR_SLOTS      = 8;
    localparam int MAX_QUERY_RESULTS = 64;
    localparam int NUM_BLOCKS        = GRID_COLUMNS * GRID_ROWS;
    localparam int BLK_W             = $clog2(NUM_BLOCKS);
    localparam int SLOT_W            = $clog2(SECTOR_SLOTS);
    localparam int SLOT_ADDR_W       = BLK_W + SLOT_W;
    localparam int BUF_W             = $clog2(MAX_QUERY_RESULTS);

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QBLOCK = 2'd2;
    localparam logic [1:0] MODE_QRECT  = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_OOG   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_TRUNC = 2'd3;

    typedef struct packed {
        logic clr_step;
        logic take;
        logic start;
        logic set_oog;
        logic blk_calc;
        logic fill_rd;
        logic fill_take;
        logic slot_rd;
        logic slot_chk;
        logic add_wr;
        logic set_full;
        logic sh_rd;
        logic sh_wr;
        logic rm_fin;
        logic next_sec;
        logic buf_rd;
        logic emit;
        logic resp;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] mode;
        logic       oog;
        logic       rect_empty;
        logic       scan_more;
        logic       hit;
        logic       full;
        logic       sh_more;
        logic       sec_last;
        logic       cnt_zero;
        logic       emit_last;
        logic       out_free;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/core/grid_spatial_index.sv @@
// Top level of the grid spatial index: configuration registers, sequencer and datapath.
`default_nettype none
// Uniform-grid spatial index over 8x8-tile sectors (64x64 sectors, 8 slots each,
// column-major block id). Modes: add, remove, list one sector, list an inclusive
// rectangle. After reset the block runs a clearing pass over the 4096 sector fill
// counters and takes no transaction until it is done; configuration writes are taken
// throughout. Each covered sector costs one read of its fill word and then reads of
// its slots in turn from the slot memory, and a remove shifts the later slots down.
// A transaction is taken only when the previous one has fully finished; listed
// objects leave through a result buffer (up to 64 entries; further hits are dropped
// and the listed results are flagged as truncated). map_width sits at address 0,
// map_height at 4.
module grid_spatial_index
    import gsi_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_mode,
    input  wire  [31:0] i_object_id,
    input  wire  [15:0] i_pos_x,
    input  wire  [15:0] i_pos_y,
    input  wire  [15:0] i_end_x,
    input  wire  [15:0] i_end_y,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [31:0] o_found_id,
    output logic [8:0]  o_found_x,
    output logic [8:0]  o_found_y,
    output logic        o_last
);
    localparam logic REG_MAP_W = 1'b0;
    localparam logic REG_MAP_H = 1'b1;

    logic [9:0] r_map_w, r_map_h;
    t_cmd       cmd;
    t_sts       sts;
    logic       wr_en;

    // register index is paddr[2]; low address bits are ignored
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAP_H) ? {22'd0, r_map_h} : {22'd0, r_map_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= 10'd512;
            r_map_h <= 10'd512;
        end else if (wr_en) begin
            if (paddr[2] == REG_MAP_W) begin
                r_map_w <= pwdata[9:0];
            end else begin
                r_map_h <= pwdata[9:0];
            end
        end
    end

    gsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gsi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_map_w     (r_map_w),
        .i_map_h     (r_map_h),
        .i_mode      (i_mode),
        .i_object_id (i_object_id),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_found_id  (o_found_id),
        .o_found_x   (o_found_x),
        .o_found_y   (o_found_y),
        .o_last      (o_last)
    );
endmodule
`default_nettype wire

@@ rtl/core/gsi_ctrl.sv @@
// Sequencer of the grid spatial index: clear pass, scans, updates and result emission.
`default_nettype none
module gsi_ctrl
    import gsi_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_BLK   = 4'd3;
    localparam logic [3:0] S_FRD   = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_SRD   = 4'd6;
    localparam logic [3:0] S_SCHK  = 4'd7;
    localparam logic [3:0] S_SHRD  = 4'd8;
    localparam logic [3:0] S_SHWR  = 4'd9;
    localparam logic [3:0] S_QDONE = 4'd10;
    localparam logic [3:0] S_ERD   = 4'd11;
    localparam logic [3:0] S_EOUT  = 4'd12;
    localparam logic [3:0] S_RESP  = 4'd13;

    logic [3:0] r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                if (i_sts.mode == MODE_QRECT) begin
                    n_state = i_sts.rect_empty ? S_QDONE : S_BLK;
                end else if (i_sts.oog) begin
                    o_cmd.set_oog = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    n_state = S_BLK;
                end
            end
            S_BLK: begin
                o_cmd.blk_calc = 1'b1;
                n_state        = S_FRD;
            end
            S_FRD: begin
                o_cmd.fill_rd = 1'b1;
                n_state       = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_take = 1'b1;
                n_state         = S_SRD;
            end
            S_SRD: begin
                if (i_sts.scan_more) begin
                    o_cmd.slot_rd = 1'b1;
                    n_state       = S_SCHK;
                end else begin
                    case (i_sts.mode)
                        MODE_ADD: begin
                            if (i_sts.full) begin
                                o_cmd.set_full = 1'b1;
                            end else begin
                                o_cmd.add_wr = 1'b1;
                            end
                            n_state = S_RESP;
                        end
                        MODE_REMOVE: n_state = S_RESP;
                        MODE_QBLOCK: n_state = S_QDONE;
                        default: begin
                            if (i_sts.sec_last) begin
                                n_state = S_QDONE;
                            end else begin
                                o_cmd.next_sec = 1'b1;
                                n_state        = S_BLK;
                            end
                        end
                    endcase
                end
            end
            S_SCHK: begin
                o_cmd.slot_chk = 1'b1;
                if (i_sts.hit && i_sts.mode == MODE_ADD) begin
                    n_state = S_RESP;
                end else if (i_sts.hit && i_sts.mode == MODE_REMOVE) begin
                    n_state = S_SHRD;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_SHRD: begin
                if (i_sts.sh_more) begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = S_SHWR;
                end else begin
                    o_cmd.rm_fin = 1'b1;
                    n_state      = S_RESP;
                end
            end
            S_SHWR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = S_SHRD;
            end
            S_QDONE: begin
                n_state = i_sts.cnt_zero ? S_RESP : S_ERD;
            end
            S_ERD: begin
                o_cmd.buf_rd = 1'b1;
                n_state      = S_EOUT;
            end
            S_EOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.emit_last ? S_IDLE : S_ERD;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/gsi_dp.sv @@
// Datapath of the grid spatial index: sector and slot stores, result buffer, output register.
`default_nettype none
module gsi_dp
    import gsi_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  wire  [9:0]  i_map_w,
    input  wire  [9:0]  i_map_h,
    input  wire  [1:0]  i_mode,
    input  wire  [31:0] i_object_id,
    input  wire  [15:0] i_pos_x,
    input  wire  [15:0] i_pos_y,
    input  wire  [15:0] i_end_x,
    input  wire  [15:0] i_end_y,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [31:0] o_found_id,
    output logic [8:0]  o_found_x,
    output logic [8:0]  o_found_y,
    output logic        o_last
);
    localparam int ENT_W = 50;
    localparam int CX_W  = $clog2(GRID_COLUMNS);
    localparam int CY_W  = $clog2(GRID_ROWS);
    localparam int XB_W  = 16 - SECTOR_SHIFT;

    logic [3:0]       m_fill [NUM_BLOCKS];
    logic [ENT_W-1:0] m_slot [NUM_BLOCKS * SECTOR_SLOTS];
    logic [ENT_W-1:0] m_buf  [MAX_QUERY_RESULTS];

    logic [BLK_W-1:0]  r_clr;
    logic [1:0]        r_mode;
    logic [31:0]       r_id;
    logic [15:0]       r_x, r_y, r_ex, r_ey;
    logic [CX_W-1:0]   r_cx;
    logic [CY_W-1:0]   r_cy;
    logic [BLK_W-1:0]  r_blk;
    logic [3:0]        r_fq;
    logic [3:0]        r_n;
    logic [3:0]        r_i;
    logic [ENT_W-1:0]  r_sd;
    logic [ENT_W-1:0]  r_bd;
    logic [BUF_W:0]    r_cnt;
    logic              r_trunc;
    logic [BUF_W-1:0]  r_e;
    logic [1:0]        r_rstat;
    logic              r_ov;

    // grid geometry
    logic [10:0]     w_sum, h_sum;
    logic [7:0]      cols_raw, rows_raw;
    logic [CX_W:0]   cols;
    logic [CY_W:0]   rows;
    logic [XB_W-1:0] bx, by, xe_raw, ye_raw;
    logic [CX_W-1:0] xe;
    logic [CY_W-1:0] ye;
    logic [BLK_W:0]  blk_full;
    logic            in_box;
    logic            offer;
    logic            out_free;
    logic [3:0]      fill_cap;

    assign w_sum    = {1'b0, i_map_w} + 11'(SECTOR_TILES - 1);
    assign h_sum    = {1'b0, i_map_h} + 11'(SECTOR_TILES - 1);
    assign cols_raw = w_sum[10:SECTOR_SHIFT];
    assign rows_raw = h_sum[10:SECTOR_SHIFT];
    assign cols = (cols_raw > 8'(GRID_COLUMNS)) ? (CX_W+1)'(GRID_COLUMNS) : cols_raw[CX_W:0];
    assign rows = (rows_raw > 8'(GRID_ROWS)) ? (CY_W+1)'(GRID_ROWS) : rows_raw[CY_W:0];

    assign bx     = r_x[15:SECTOR_SHIFT];
    assign by     = r_y[15:SECTOR_SHIFT];
    assign xe_raw = r_ex[15:SECTOR_SHIFT];
    assign ye_raw = r_ey[15:SECTOR_SHIFT];
    assign xe = (xe_raw >= XB_W'(cols)) ? CX_W'(cols - 1'b1) : xe_raw[CX_W-1:0];
    assign ye = (ye_raw >= XB_W'(rows)) ? CY_W'(rows - 1'b1) : ye_raw[CY_W-1:0];

    assign blk_full = (BLK_W+1)'(r_cx * rows) + (BLK_W+1)'(r_cy);

    assign in_box = ({7'd0, r_sd[17:9]} >= r_x) && ({7'd0, r_sd[8:0]} >= r_y)
                 && ({7'd0, r_sd[17:9]} <= r_ex) && ({7'd0, r_sd[8:0]} <= r_ey);
    assign offer  = i_cmd.slot_chk
                 && (r_mode == MODE_QBLOCK || (r_mode == MODE_QRECT && in_box));
    assign out_free = !r_ov || !i_out_stall;
    assign fill_cap = (r_fq > 4'(SECTOR_SLOTS)) ? 4'(SECTOR_SLOTS) : r_fq;

    always_comb begin
        o_sts            = '0;
        o_sts.clr_done   = (r_clr == BLK_W'(NUM_BLOCKS - 1));
        o_sts.mode       = r_mode;
        o_sts.oog        = (bx >= XB_W'(cols)) || (by >= XB_W'(rows));
        o_sts.rect_empty = (cols == '0) || (rows == '0)
                        || (bx > XB_W'(xe)) || (by > XB_W'(ye));
        o_sts.scan_more  = (r_i < r_n);
        o_sts.hit        = (r_sd[49:18] == r_id);
        o_sts.full       = (r_n >= 4'(SECTOR_SLOTS));
        o_sts.sh_more    = ((r_i + 4'd1) < r_n);
        o_sts.sec_last   = (r_cx == xe) && (r_cy == ye);
        o_sts.cnt_zero   = (r_cnt == '0);
        o_sts.emit_last  = ({1'b0, r_e} == (r_cnt - 1'b1));
        o_sts.out_free   = out_free;
    end

    // sector fill store: clear pass, add and remove share one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            m_fill[r_clr] <= 4'd0;
        end else if (i_cmd.add_wr) begin
            m_fill[r_blk] <= r_n + 4'd1;
        end else if (i_cmd.rm_fin) begin
            m_fill[r_blk] <= r_n - 4'd1;
        end
        if (i_cmd.fill_rd) begin
            r_fq <= m_fill[r_blk];
        end
    end

    // slot store
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            m_slot[{r_blk, r_n[SLOT_W-1:0]}] <= {r_id, r_x[8:0], r_y[8:0]};
        end else if (i_cmd.sh_wr) begin
            m_slot[{r_blk, r_i[SLOT_W-1:0]}] <= r_sd;
        end
        if (i_cmd.slot_rd) begin
            r_sd <= m_slot[{r_blk, r_i[SLOT_W-1:0]}];
        end else if (i_cmd.sh_rd) begin
            r_sd <= m_slot[{r_blk, SLOT_W'(r_i + 4'd1)}];
        end
    end

    // result buffer
    always_ff @(posedge i_clk) begin
        if (offer && !r_cnt[BUF_W]) begin
            m_buf[r_cnt[BUF_W-1:0]] <= r_sd;
        end
        if (i_cmd.buf_rd) begin
            r_bd <= m_buf[r_e];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode <= i_mode;
            r_id   <= i_object_id;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_ex   <= i_end_x;
            r_ey   <= i_end_y;
        end
        if (i_cmd.start) begin
            r_cx    <= bx[CX_W-1:0];
            r_cy    <= by[CY_W-1:0];
            r_cnt   <= '0;
            r_trunc <= 1'b0;
            r_e     <= '0;
            r_rstat <= STAT_OK;
        end
        if (i_cmd.set_oog) begin
            r_rstat <= STAT_OOG;
        end
        if (i_cmd.set_full) begin
            r_rstat <= STAT_FULL;
        end
        if (i_cmd.blk_calc) begin
            r_blk <= blk_full[BLK_W-1:0];
        end
        if (i_cmd.fill_take) begin
            r_n <= fill_cap;
            r_i <= '0;
        end
        // advance past a slot unless an add or remove stops on it
        if (i_cmd.slot_chk && !(o_sts.hit && (r_mode == MODE_ADD || r_mode == MODE_REMOVE))) begin
            r_i <= r_i + 4'd1;
        end
        if (i_cmd.sh_wr) begin
            r_i <= r_i + 4'd1;
        end
        if (offer) begin
            if (r_cnt[BUF_W]) begin
                r_trunc <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.next_sec) begin
            if (r_cy == ye) begin
                r_cy <= by[CY_W-1:0];
                r_cx <= r_cx + 1'b1;
            end else begin
                r_cy <= r_cy + 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_e <= r_e + 1'b1;
        end
    end

    // clear counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.emit || i_cmd.resp) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
        if (i_cmd.emit) begin
            o_status   <= r_trunc ? STAT_TRUNC : STAT_OK;
            o_found    <= 1'b1;
            o_found_id <= r_bd[49:18];
            o_found_x  <= r_bd[17:9];
            o_found_y  <= r_bd[8:0];
            o_last     <= o_sts.emit_last;
        end else if (i_cmd.resp) begin
            o_status   <= r_rstat;
            o_found    <= 1'b0;
            o_found_id <= '0;
            o_found_x  <= '0;
            o_found_y  <= '0;
            o_last     <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;
endmodule
`default_nettype wire
